// ----- rtl/unused_vertex_compaction_assert.svh -----
// Assertion macros for the unused vertex compaction block.
// Included by the RTL files that carry concurrent checks; needs no package.
`ifndef UNUSED_VERTEX_COMPACTION_ASSERT_SVH
`define UNUSED_VERTEX_COMPACTION_ASSERT_SVH

// Check that prop holds on every rising edge outside reset.
`define UVC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that cond never holds on a rising edge outside reset.
`define UVC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `UVC_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

// ----- rtl/uvc_pkg.sv -----
// Shared constants for the unused vertex compaction block.
// Used by unused_vertex_compaction; depends on nothing.
`timescale 1ns / 1ps

package uvc_pkg;

  localparam int unsigned MaxVertices = 1024;
  localparam int unsigned IdxW        = 10;
  localparam int unsigned CntW        = 11;
  localparam int unsigned DataW       = 64;
  localparam int unsigned ActW        = 2;
  localparam int unsigned KindW       = 2;

  localparam logic [ActW-1:0] ActMark    = 2'd0;
  localparam logic [ActW-1:0] ActPresent = 2'd1;
  localparam logic [ActW-1:0] ActRemap   = 2'd2;
  localparam logic [ActW-1:0] ActFinish  = 2'd3;

  localparam logic [KindW-1:0] KindKept    = 2'd0;
  localparam logic [KindW-1:0] KindCorner  = 2'd1;
  localparam logic [KindW-1:0] KindSummary = 2'd2;

endpackage

// ----- rtl/unused_vertex_compaction.sv -----
// Unused vertex compaction: marks referenced vertices, renumbers kept ones, remaps corners.
// Depends on uvc_pkg and unused_vertex_compaction_assert.svh.
//
//   channel | valid / stall          | payload
//   --------+------------------------+--------------------------------------------------
//   input   | in_valid_i / in_stall_o | action_i, vertex_index_i, vertex_data_i
//   output  | out_valid_o / out_stall_i | result_kind_o, new_index_o, original_index_o,
//           |                        | vertex_data_res_o, removed_count_o, bad_reference_o
//
// One beat per cycle while in_stall_o is low; the accepting edge does the used-bit and
// index-map read, and the result register loads from the resolve register when it advances.
// After reset and after every finish beat a clearing pass sweeps the used-bit memory,
// one entry a cycle, with the input stalled.
// Output stall backs up through the resolve register to in_stall_o.
`timescale 1ns / 1ps
`include "unused_vertex_compaction_assert.svh"

module unused_vertex_compaction (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [uvc_pkg::ActW-1:0]     action_i,
  input  logic [uvc_pkg::IdxW-1:0]     vertex_index_i,
  input  logic [uvc_pkg::DataW-1:0]    vertex_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [uvc_pkg::KindW-1:0]    result_kind_o,
  output logic [uvc_pkg::IdxW-1:0]     new_index_o,
  output logic [uvc_pkg::IdxW-1:0]     original_index_o,
  output logic [uvc_pkg::DataW-1:0]    vertex_data_res_o,
  output logic [uvc_pkg::CntW-1:0]     removed_count_o,
  output logic                         bad_reference_o
);

  localparam logic [uvc_pkg::CntW-1:0] CntFull = uvc_pkg::CntW'(uvc_pkg::MaxVertices);
  localparam logic [uvc_pkg::IdxW-1:0] IdxLast = uvc_pkg::IdxW'(uvc_pkg::MaxVertices - 1);

  logic                        used_mem [uvc_pkg::MaxVertices];
  logic [uvc_pkg::IdxW-1:0]    map_mem  [uvc_pkg::MaxVertices];

  logic                        clr_active_q, clr_active_d;
  logic [uvc_pkg::IdxW-1:0]    clr_addr_q, clr_addr_d;
  logic [uvc_pkg::CntW-1:0]    pres_cnt_q, pres_cnt_d;
  logic [uvc_pkg::CntW-1:0]    kept_cnt_q, kept_cnt_d;
  logic                        ovf_q, ovf_d;

  logic                        s1_valid_q, s1_valid_d;
  logic [uvc_pkg::ActW-1:0]    s1_act_q;
  logic [uvc_pkg::IdxW-1:0]    s1_idx_q;
  logic [uvc_pkg::DataW-1:0]   s1_data_q;
  logic [uvc_pkg::CntW-1:0]    s1_cnt_q;
  logic                        s1_lt_q;
  logic                        s1_ovf_q;
  logic                        s1_byp_q;
  logic [uvc_pkg::IdxW-1:0]    s1_byp_val_q;
  logic                        used_rd_q;
  logic [uvc_pkg::IdxW-1:0]    map_rd_q;

  logic                        out_valid_q;
  logic [uvc_pkg::KindW-1:0]   out_kind_q, out_kind_d;
  logic [uvc_pkg::IdxW-1:0]    out_new_q, out_new_d;
  logic [uvc_pkg::IdxW-1:0]    out_orig_q, out_orig_d;
  logic [uvc_pkg::DataW-1:0]   out_data_q, out_data_d;
  logic [uvc_pkg::CntW-1:0]    out_removed_q, out_removed_d;
  logic                        out_bad_q, out_bad_d;

  logic                        s1_adv;
  logic                        in_acc;
  logic                        full;
  logic                        s1_load;
  logic [uvc_pkg::IdxW-1:0]    rd_addr;
  logic                        used_we;
  logic [uvc_pkg::IdxW-1:0]    used_wa;
  logic                        used_wd;
  logic                        s1_hit;
  logic                        s1_produce;
  logic                        map_we;
  logic                        remap_ok;
  logic                        byp_d;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = clr_active_q || (s1_valid_q && !s1_adv);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (pres_cnt_q == CntFull);

  assign s1_load = in_acc && ((action_i == uvc_pkg::ActRemap) ||
                              (action_i == uvc_pkg::ActFinish) ||
                              ((action_i == uvc_pkg::ActPresent) && !full));

  assign rd_addr = (action_i == uvc_pkg::ActPresent) ? pres_cnt_q[uvc_pkg::IdxW-1:0]
                                                     : vertex_index_i;

  assign used_we = clr_active_q ||
                   (in_acc && (action_i == uvc_pkg::ActMark) &&
                    (pres_cnt_q == '0) && !ovf_q);
  assign used_wa = clr_active_q ? clr_addr_q : vertex_index_i;
  assign used_wd = !clr_active_q;

  assign s1_hit     = (s1_act_q == uvc_pkg::ActPresent) && used_rd_q;
  assign s1_produce = (s1_act_q != uvc_pkg::ActPresent) || used_rd_q;
  assign map_we     = s1_valid_q && s1_adv && s1_hit;
  assign remap_ok   = s1_lt_q && used_rd_q;

  // forward a map entry being written in the same edge as its read
  assign byp_d = s1_valid_q && s1_hit && (s1_idx_q == vertex_index_i);

  always_ff @(posedge clk_i) begin
    if (used_we) begin
      used_mem[used_wa] <= used_wd;
    end
    if (s1_load) begin
      used_rd_q <= used_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[s1_idx_q] <= kept_cnt_q[uvc_pkg::IdxW-1:0];
    end
    if (s1_load) begin
      map_rd_q <= map_mem[rd_addr];
    end
  end

  always_comb begin
    clr_active_d = clr_active_q;
    clr_addr_d   = clr_addr_q;
    pres_cnt_d   = pres_cnt_q;
    ovf_d        = ovf_q;
    kept_cnt_d   = kept_cnt_q;
    s1_valid_d   = s1_valid_q;

    if (clr_active_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == IdxLast) begin
        clr_active_d = 1'b0;
      end
    end

    if (in_acc && (action_i == uvc_pkg::ActPresent)) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        pres_cnt_d = pres_cnt_q + 1'b1;
      end
    end
    if (in_acc && (action_i == uvc_pkg::ActFinish)) begin
      pres_cnt_d   = '0;
      ovf_d        = 1'b0;
      clr_active_d = 1'b1;
      clr_addr_d   = '0;
    end

    if (s1_valid_q && s1_adv) begin
      if (s1_hit) begin
        kept_cnt_d = kept_cnt_q + 1'b1;
      end else if (s1_act_q == uvc_pkg::ActFinish) begin
        kept_cnt_d = '0;
      end
    end

    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
      pres_cnt_q   <= '0;
      kept_cnt_q   <= '0;
      ovf_q        <= 1'b0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_addr_q   <= clr_addr_d;
      pres_cnt_q   <= pres_cnt_d;
      kept_cnt_q   <= kept_cnt_d;
      ovf_q        <= ovf_d;
      s1_valid_q   <= s1_valid_d;
      if (s1_adv) begin
        out_valid_q <= s1_valid_q && s1_produce;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_act_q     <= action_i;
      s1_idx_q     <= rd_addr;
      s1_data_q    <= vertex_data_i;
      s1_cnt_q     <= pres_cnt_q;
      s1_lt_q      <= ({1'b0, vertex_index_i} < pres_cnt_q);
      s1_ovf_q     <= ovf_q;
      s1_byp_q     <= byp_d;
      s1_byp_val_q <= kept_cnt_q[uvc_pkg::IdxW-1:0];
    end
  end

  always_comb begin
    out_kind_d    = uvc_pkg::KindKept;
    out_new_d     = '0;
    out_orig_d    = '0;
    out_data_d    = '0;
    out_removed_d = '0;
    out_bad_d     = 1'b0;
    case (s1_act_q)
      uvc_pkg::ActPresent: begin
        out_kind_d = uvc_pkg::KindKept;
        out_new_d  = kept_cnt_q[uvc_pkg::IdxW-1:0];
        out_orig_d = s1_idx_q;
        out_data_d = s1_data_q;
      end
      uvc_pkg::ActRemap: begin
        out_kind_d = uvc_pkg::KindCorner;
        if (remap_ok) begin
          out_new_d = s1_byp_q ? s1_byp_val_q : map_rd_q;
        end
        out_bad_d = !remap_ok || s1_ovf_q;
      end
      uvc_pkg::ActFinish: begin
        out_kind_d    = uvc_pkg::KindSummary;
        out_removed_d = s1_cnt_q - kept_cnt_q;
        out_bad_d     = s1_ovf_q;
      end
      default: begin
        out_kind_d = uvc_pkg::KindKept;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_kind_q    <= out_kind_d;
      out_new_q     <= out_new_d;
      out_orig_q    <= out_orig_d;
      out_data_q    <= out_data_d;
      out_removed_q <= out_removed_d;
      out_bad_q     <= out_bad_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = out_kind_q;
  assign new_index_o       = out_new_q;
  assign original_index_o  = out_orig_q;
  assign vertex_data_res_o = out_data_q;
  assign removed_count_o   = out_removed_q;
  assign bad_reference_o   = out_bad_q;

  `UVC_ASSERT(a_clear_blocks_input, clk_i, rst_ni, clr_active_q |-> in_stall_o, "beat taken while clearing")
  `UVC_ASSERT(a_clear_ends, clk_i, rst_ni, (clr_active_q && (clr_addr_q == IdxLast) && !(in_acc && (action_i == uvc_pkg::ActFinish))) |=> !clr_active_q, "clearing pass overran")
  `UVC_ASSERT(a_s1_holds, clk_i, rst_ni, (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_act_q) && $stable(s1_idx_q)), "held beat lost in resolve stage")
  `UVC_ASSERT_NEVER(a_kept_dense, clk_i, rst_ni, out_valid_q && (out_kind_q == uvc_pkg::KindKept) && (out_new_q > out_orig_q), "dense index above original")
  `UVC_ASSERT_NEVER(a_kind_code, clk_i, rst_ni, out_valid_q && (out_kind_q != uvc_pkg::KindKept) && (out_kind_q != uvc_pkg::KindCorner) && (out_kind_q != uvc_pkg::KindSummary), "meaningless result kind")

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for unused_vertex_compaction: queued mesh beats, own compaction predictor.
// Depends on uvc_pkg and the unused_vertex_compaction RTL.
`timescale 1ns / 1ps

module tb;
  import uvc_pkg::*;

  localparam int RandomBeats = 150;
  localparam int CycleLimit  = 1000000;
  localparam int SettleCycles = 16;

  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [IdxW-1:0]  vidx;
    logic [DataW-1:0] vdata;
    bit               drain_first;
  } mesh_beat_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [IdxW-1:0]  new_index;
    logic [IdxW-1:0]  original_index;
    logic [DataW-1:0] data;
    logic [CntW-1:0]  removed;
    logic             bad;
  } compaction_result_t;

  logic clk_i = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic out_valid;
  logic out_stall;
  mesh_beat_t cur_beat;
  compaction_result_t seen;

  mesh_beat_t         pending_beats[$];
  compaction_result_t expected_results[$];

  bit               used_mark[MaxVertices];
  logic [IdxW-1:0]  dense_of[MaxVertices];
  logic [CntW-1:0]  kept_so_far;
  logic [CntW-1:0]  presented_so_far;
  bit               capacity_overrun;

  int  total_beats;
  int  beats_driven;
  int  fault_count;
  int  cycle_count;
  bit  beat_accepted;

  always #6 clk_i = ~clk_i;

  unused_vertex_compaction u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .action_i          (cur_beat.action),
    .vertex_index_i    (cur_beat.vidx),
    .vertex_data_i     (cur_beat.vdata),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .result_kind_o     (seen.kind),
    .new_index_o       (seen.new_index),
    .original_index_o  (seen.original_index),
    .vertex_data_res_o (seen.data),
    .removed_count_o   (seen.removed),
    .bad_reference_o   (seen.bad)
  );

  function automatic logic [DataW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit predict_compaction(input mesh_beat_t b, output compaction_result_t r);
    logic [CntW-1:0] pos;
    bit ok;
    r = '0;
    case (b.action)
      ActMark: begin
        if (presented_so_far == 0 && !capacity_overrun) used_mark[b.vidx] = 1'b1;
        return 1'b0;
      end
      ActPresent: begin
        pos = presented_so_far;
        if (pos >= MaxVertices) begin
          capacity_overrun = 1'b1;
          return 1'b0;
        end
        presented_so_far = pos + 1'b1;
        if (!used_mark[pos[IdxW-1:0]]) return 1'b0;
        dense_of[pos[IdxW-1:0]] = kept_so_far[IdxW-1:0];
        r.kind = KindKept;
        r.new_index = kept_so_far[IdxW-1:0];
        r.original_index = pos[IdxW-1:0];
        r.data = b.vdata;
        kept_so_far = kept_so_far + 1'b1;
        return 1'b1;
      end
      ActRemap: begin
        ok = ({1'b0, b.vidx} < presented_so_far) && used_mark[b.vidx];
        r.kind = KindCorner;
        r.new_index = ok ? dense_of[b.vidx] : '0;
        r.bad = !ok || capacity_overrun;
        return 1'b1;
      end
      default: begin
        r.kind = KindSummary;
        r.removed = presented_so_far - kept_so_far;
        r.bad = capacity_overrun;
        foreach (used_mark[i]) used_mark[i] = 1'b0;
        kept_so_far = '0;
        presented_so_far = '0;
        capacity_overrun = 1'b0;
        return 1'b1;
      end
    endcase
  endfunction

  task automatic queue_beat(input logic [ActW-1:0] action, input logic [IdxW-1:0] vidx,
                            input logic [DataW-1:0] vdata, input bit drain_first);
    mesh_beat_t b;
    b.action = action;
    b.vidx = vidx;
    b.vdata = vdata;
    b.drain_first = drain_first;
    pending_beats.insert(pending_beats.size(), b);
  endtask

  task automatic queue_stray_beat();
    if ($urandom_range(0, 24) == 0)
      queue_beat(ActW'($urandom_range(0, 3)), IdxW'($urandom_range(0, 1023)), rand64(), 1'b0);
  endtask

  task automatic queue_small_mesh();
    int corners[$];
    int nv;
    int n_corner;
    int i;
    bit drain;
    nv = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 90) : $urandom_range(0, 20);
    n_corner = $urandom_range(0, 2 * nv + 2);
    drain = ($urandom_range(0, 4) == 0);
    for (i = 0; i < n_corner; i++) begin
      if (nv == 0 || $urandom_range(0, 9) == 0)
        corners.insert(corners.size(), $urandom_range(0, 1023));
      else
        corners.insert(corners.size(), $urandom_range(0, nv - 1));
    end
    for (i = 0; i < n_corner; i++) begin
      queue_beat(ActMark, IdxW'(corners[i]), rand64(), drain && i == 0);
      queue_stray_beat();
    end
    for (i = 0; i < nv; i++) begin
      queue_beat(ActPresent, IdxW'($urandom_range(0, 1023)), rand64(),
                 drain && n_corner == 0 && i == 0);
      queue_stray_beat();
    end
    for (i = 0; i < n_corner; i++) begin
      queue_beat(ActRemap, IdxW'(corners[$urandom_range(0, n_corner - 1)]), rand64(), 1'b0);
      queue_stray_beat();
    end
    queue_beat(ActFinish, IdxW'($urandom_range(0, 1023)), rand64(), 1'b0);
  endtask

  // Present past capacity; with no early marks every vertex is dropped.
  task automatic queue_full_mesh(input bit early_marks);
    int marked[$];
    int i;
    if (early_marks) begin
      marked = '{0, 1, 511, 512, 1022, 1023};
      repeat (30) marked.insert(marked.size(), $urandom_range(0, 1023));
    end
    foreach (marked[k]) queue_beat(ActMark, IdxW'(marked[k]), rand64(), k == 0);
    for (i = 0; i < MaxVertices + 3; i++) begin
      queue_beat(ActPresent, IdxW'($urandom_range(0, 1023)), rand64(), i == 0 && !early_marks);
      if (i == 500) queue_beat(ActMark, 10'd700, rand64(), 1'b0);
      if (i == 800)
        queue_beat(ActRemap, IdxW'(marked.size() > 0 ? marked[1] : 0), rand64(), 1'b0);
    end
    repeat (2) queue_beat(ActMark, IdxW'($urandom_range(0, 1023)), rand64(), 1'b0);
    foreach (marked[k]) queue_beat(ActRemap, IdxW'(marked[k]), rand64(), 1'b0);
    repeat (4) queue_beat(ActRemap, IdxW'($urandom_range(0, 1023)), rand64(), 1'b0);
    queue_beat(ActFinish, 10'h3FF, rand64(), 1'b0);
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin : monitor
    compaction_result_t want;
    compaction_result_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = seen;
        if (expected_results.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected result at cycle %0d: kind %0d", cycle_count, got.kind);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fault_count++;
            if (fault_count <= 10)
              $display({"mismatch at cycle %0d (expected/actual): kind %0d/%0d new %0d/%0d ",
                        "orig %0d/%0d data %h/%h removed %0d/%0d bad %0d/%0d"},
                       cycle_count, want.kind, got.kind, want.new_index, got.new_index,
                       want.original_index, got.original_index, want.data, got.data,
                       want.removed, got.removed, want.bad, got.bad);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (predict_compaction(cur_beat, want))
          expected_results.insert(expected_results.size(), want);
      end
    end
    beat_accepted <= rst_n && in_valid && !in_stall;
  end

  always @(negedge clk_i) begin : driver
    int sender_pct;
    int receiver_pct;
    if (rst_n) begin
      if (beats_driven * 3 < total_beats) begin
        sender_pct = 11;
        receiver_pct = 80;
      end else if (beats_driven * 3 < 2 * total_beats) begin
        sender_pct = 80;
        receiver_pct = 11;
      end else begin
        sender_pct = 0;
        receiver_pct = 0;
      end
      if (!in_valid || beat_accepted) begin
        if (pending_beats.size() != 0 && $urandom_range(0, 99) >= sender_pct &&
            !(pending_beats[0].drain_first && expected_results.size() != 0)) begin
          cur_beat <= pending_beats.pop_front();
          in_valid <= 1'b1;
          beats_driven++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < receiver_pct);
    end
  end

  initial begin : stimulus
    int random_beats;
    int queued_prior;
    int seg;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    cur_beat = '0;
    beat_accepted = 1'b0;
    kept_so_far = '0;
    presented_so_far = '0;
    capacity_overrun = 1'b0;
    foreach (used_mark[i]) used_mark[i] = 1'b0;

    queue_beat(ActFinish, 10'h000, '1, 1'b1);
    queue_beat(ActMark, 10'h000, '0, 1'b1);
    queue_beat(ActMark, 10'h3FF, rand64(), 1'b0);
    queue_beat(ActMark, 10'h002, rand64(), 1'b0);
    queue_beat(ActRemap, 10'h002, rand64(), 1'b0);
    queue_beat(ActPresent, 10'h155, '1, 1'b0);
    queue_beat(ActPresent, 10'h2AA, '0, 1'b0);
    queue_beat(ActMark, 10'h001, rand64(), 1'b0);
    queue_beat(ActPresent, 10'h000, 64'hA5A5_5A5A_0F0F_F0F0, 1'b0);
    queue_beat(ActRemap, 10'h000, rand64(), 1'b0);
    queue_beat(ActRemap, 10'h001, rand64(), 1'b0);
    queue_beat(ActRemap, 10'h002, rand64(), 1'b0);
    queue_beat(ActRemap, 10'h3FF, rand64(), 1'b0);
    queue_beat(ActFinish, 10'h3FF, rand64(), 1'b0);
    queue_beat(ActRemap, 10'h000, rand64(), 1'b1);
    queue_beat(ActFinish, 10'h000, rand64(), 1'b0);

    random_beats = 0;
    for (seg = 0; seg < 3; seg++) begin
      while (random_beats < (seg + 1) * RandomBeats / 3) begin
        queued_prior = pending_beats.size();
        queue_small_mesh();
        random_beats += pending_beats.size() - queued_prior;
      end
      if (seg == 0) queue_full_mesh(1'b1);
    end
    total_beats = pending_beats.size();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (fault_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/uvc_pkg.sv
rtl/unused_vertex_compaction.sv
tb/tb.sv
